// ===== src/amsel_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes and types for the measured backend argmin selector
package amsel_pkg;

  localparam int unsigned FeatW  = 32;
  localparam int unsigned CycW   = 64;
  localparam int unsigned BytesW = 64;
  localparam int unsigned IdW    = 32;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned QFrac  = 16;

  // dividend keeps only the cycle bits that survive the q16 shift
  localparam int unsigned DvdW     = CycW - QFrac;
  localparam int unsigned QuoW     = ScoreW;
  localparam int unsigned StepCntW = $clog2(QuoW);

  localparam int unsigned InDataW  = FeatW + CycW + BytesW + IdW;
  localparam int unsigned OutDataW = IdW + ScoreW;

  localparam logic StatusFound = 1'b0;
  localparam logic StatusNone  = 1'b1;

  localparam logic [ScoreW-1:0] ScoreSat = {ScoreW{1'b1}};

  // control from the sequencer to the best tracker
  typedef struct packed {
    logic upd;   // one record finished scoring
    logic elig;  // record passed and its features are offered
    logic last;  // record closes the list
  } best_ctl_t;

endpackage

// ===== src/amsel_div.sv =====
`timescale 1ns / 1ps
// radix-2 restoring divider, one quotient bit per cycle through one subtractor
module amsel_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [amsel_pkg::DvdW-1:0]    dividend_i,
  input  logic [amsel_pkg::BytesW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [amsel_pkg::QuoW-1:0]    quo_o
);
  import amsel_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [BytesW-1:0]   rem_q, rem_d;
  logic [BytesW-1:0]   div_q, div_d;
  // low dividend bits shift out at the top while quotient bits shift in
  logic [QuoW-1:0]     low_q, low_d;

  logic [BytesW:0]     rem_sh;
  logic [BytesW:0]     diff;
  logic                fits;

  assign rem_sh = {rem_q, low_q[QuoW-1]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign fits   = ~diff[BytesW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    low_d  = low_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      div_d  = divisor_i;
      // upper half of the shifted dividend, known to be below the divisor
      rem_d  = {{(BytesW-(DvdW-QFrac)){1'b0}}, dividend_i[DvdW-1:QFrac]};
      low_d  = {dividend_i[QFrac-1:0], {(QuoW-QFrac){1'b0}}};
    end else if (busy_q) begin
      rem_d = fits ? diff[BytesW-1:0] : rem_sh[BytesW-1:0];
      low_d = {low_q[QuoW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    low_q <= low_d;
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not go busy after start");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !start_i) |=> done_q)
    else $error("divider missed done after last step");

endmodule

// ===== src/amsel_best.sv =====
`timescale 1ns / 1ps
// running minimum with id tiebreak and the result register
module amsel_best (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  amsel_pkg::best_ctl_t          ctl_i,
  input  logic [amsel_pkg::ScoreW-1:0]  score_i,
  input  logic [amsel_pkg::IdW-1:0]     id_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic                          res_free_o,
  output logic                          res_status_o,
  output logic [amsel_pkg::IdW-1:0]     res_id_o,
  output logic [amsel_pkg::ScoreW-1:0]  res_score_o
);
  import amsel_pkg::*;

  logic              have_q, have_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [IdW-1:0]    best_id_q, best_id_d;
  logic              res_valid_q, res_valid_d;
  logic              res_status_q, res_status_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic [ScoreW-1:0] res_score_q, res_score_d;
  logic              win;

  assign win = ctl_i.elig && (!have_q || (score_i < best_score_q) ||
               ((score_i == best_score_q) && (id_i < best_id_q)));

  assign res_free_o = !res_valid_q || res_ready_i;

  always_comb begin
    have_d       = have_q;
    best_score_d = best_score_q;
    best_id_d    = best_id_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_score_d  = res_score_q;
    if (ctl_i.upd) begin
      if (ctl_i.last) begin
        res_valid_d = 1'b1;
        if (win) begin
          res_status_d = StatusFound;
          res_id_d     = id_i;
          res_score_d  = score_i;
        end else if (have_q) begin
          res_status_d = StatusFound;
          res_id_d     = best_id_q;
          res_score_d  = best_score_q;
        end else begin
          res_status_d = StatusNone;
          res_id_d     = '0;
          res_score_d  = '0;
        end
        // list closed, back to the empty state
        have_d       = 1'b0;
        best_score_d = ScoreSat;
        best_id_d    = '0;
      end else if (win) begin
        have_d       = 1'b1;
        best_score_d = score_i;
        best_id_d    = id_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      best_score_q <= ScoreSat;
      best_id_q    <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      have_q       <= have_d;
      best_score_q <= best_score_d;
      best_id_q    <= best_id_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_score_q  <= res_score_d;
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_id_o     = res_id_q;
  assign res_score_o  = res_score_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.upd && ctl_i.last) |-> (!res_valid_q || res_ready_i))
    else $error("result register overwritten before it was taken");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.upd && ctl_i.last) |=> (!have_q && best_score_q == ScoreSat))
    else $error("tracker not cleared after end of list");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.upd && ctl_i.last && !ctl_i.elig && !have_q) |=>
      (res_status_q == StatusNone && res_id_q == '0 && res_score_q == '0))
    else $error("empty list result carries nonzero fields");

endmodule

// ===== src/measured_backend_argmin_select_core.sv =====
`timescale 1ns / 1ps
// top level: measured backend argmin selector with q16 cycles-per-byte scoring
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: needed_features, cycle_count,
//                                            payload_bytes, candidate_id;
//                                            tuser: passed; tlast: last_item
//  m_axis    out  m_axis_tvalid/tready       tdata: chosen_id, chosen_score;
//                                            tuser: status
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: platform_features
//
//  an eligible, unsaturated record goes from its accept in idle through the divide
//  state, where the restoring divider runs its 32 steps and raises done, and then
//  through the update state before another record is accepted; an ineligible or
//  saturated record skips the divider and goes from idle straight to the update
//  state; a last record waits in the update state while the result register still
//  holds an untaken result; s_axis stays low throughout the work on one record
//  reset clears the feature mask, the running best and the result valid
module measured_backend_argmin_select_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [amsel_pkg::FeatW-1:0]     cfg_data_i,    // platform_features
  // measurement records
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] needed_features, [95:32] cycle_count, [159:96] payload_bytes,
  // [191:160] candidate_id
  input  logic [amsel_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,  // [0] passed
  input  logic                            s_axis_tlast,  // last_item
  // selection result
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] chosen_id, [63:32] chosen_score
  output logic [amsel_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser   // [0] status
);
  import amsel_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FeatW-1:0]  feat_q, feat_d;
  logic [IdW-1:0]    id_q, id_d;
  logic              last_q, last_d;
  logic              elig_q, elig_d;
  logic              sat_q, sat_d;

  // unpacked request fields
  logic [FeatW-1:0]  in_needed;
  logic [CycW-1:0]   in_cyc;
  logic [BytesW-1:0] in_bytes;
  logic [IdW-1:0]    in_id;
  logic              in_accept;
  logic              in_elig;
  logic              in_sat;

  logic              div_start;
  logic              div_done;
  logic [QuoW-1:0]   div_quo;

  best_ctl_t         best_ctl;
  logic [ScoreW-1:0] upd_score;
  logic              res_free;
  logic              res_status;
  logic [IdW-1:0]    res_id;
  logic [ScoreW-1:0] res_score;

  assign in_needed = s_axis_tdata[FeatW-1:0];
  assign in_cyc    = s_axis_tdata[FeatW+CycW-1:FeatW];
  assign in_bytes  = s_axis_tdata[FeatW+CycW+BytesW-1:FeatW+CycW];
  assign in_id     = s_axis_tdata[InDataW-1:FeatW+CycW+BytesW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // every needed feature must be offered by the platform
  assign in_elig = s_axis_tuser && ((in_needed & ~feat_q) == '0);

  // saturate on zero bytes, cycles beyond 48 bits, or a quotient of 2^32 or
  // more, which is cycles >= bytes * 2^16
  assign in_sat = (in_bytes == '0) || (in_cyc[CycW-1:DvdW] != '0) ||
                  ((in_bytes[BytesW-1:QuoW] == '0) &&
                   (in_cyc[DvdW-1:0] >= {in_bytes[QuoW-1:0], {QFrac{1'b0}}}));

  assign div_start = in_accept && in_elig && !in_sat;

  // config is always taken; eligibility is latched at accept, so a write
  // never changes a record already in work
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    feat_d  = feat_q;
    id_d    = id_q;
    last_d  = last_q;
    elig_d  = elig_q;
    sat_d   = sat_q;
    if (cfg_valid_i) begin
      feat_d = cfg_data_i;
    end
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          id_d    = in_id;
          last_d  = s_axis_tlast;
          elig_d  = in_elig;
          sat_d   = in_sat;
          state_d = div_start ? StDiv : StUpd;
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (!last_q || res_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      feat_q  <= '0;
    end else begin
      state_q <= state_d;
      feat_q  <= feat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    last_q <= last_d;
    elig_q <= elig_d;
    sat_q  <= sat_d;
  end

  amsel_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_cyc[DvdW-1:0]),
    .divisor_i  (in_bytes),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // score is the divider result unless the record saturated up front
  assign upd_score = sat_q ? ScoreSat : div_quo;

  assign best_ctl.upd  = (state_q == StUpd) && (!last_q || res_free);
  assign best_ctl.elig = elig_q;
  assign best_ctl.last = last_q;

  amsel_best u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (best_ctl),
    .score_i      (upd_score),
    .id_i         (id_q),
    .res_ready_i  (m_axis_tready),
    .res_valid_o  (m_axis_tvalid),
    .res_free_o   (res_free),
    .res_status_o (res_status),
    .res_id_o     (res_id),
    .res_score_o  (res_score)
  );

  assign m_axis_tdata = {res_score, res_id};
  assign m_axis_tuser = res_status;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StUpd) |-> !s_axis_tready)
    else $error("request taken while a record is in work");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == StDiv && !sat_q && elig_q))
    else $error("divider started for a record that needs no division");

endmodule
